>>> rtl/dog7_pkg.sv
// ----------------------------------------------------------------------------
// dog7_pkg
// shared constants, types and kernel weights of the 7x7 derivative-of-gaussian
// gradient unit
// ----------------------------------------------------------------------------
package dog7_pkg;

    // frame store geometry
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 512;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS * MAX_ROWS);

    // field widths
    localparam int COL_W = 9;
    localparam int ROW_W = 9;
    localparam int PIX_W = 8;
    localparam int CFG_W = 10;
    localparam int OUT_W = 23;

    // window
    localparam int WIN   = 7;
    localparam int HALF  = 3;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WIN - 1);

    // signed window coordinate: holds center + HALF, a negative offset and any limit
    localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int DIM_W   = ($clog2(MAX_DIM) > CFG_W) ? $clog2(MAX_DIM) : CFG_W;
    localparam int CRD_W   = DIM_W + 2;

    // weights and products
    localparam int WGT_W = 13;
    localparam int PRD_W = PIX_W + 1 + WGT_W;

    // input item codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W        = 1;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // horizontal kernel x 10000, [window row][window column]; vertical is the transpose
    localparam logic signed [WGT_W-1:0] DOG_W [WIN][WIN] = '{
        '{  -13'sd2,   -13'sd13,   -13'sd30, 13'sd0,   13'sd30,   13'sd13,   13'sd2 },
        '{ -13'sd20,  -13'sd161,  -13'sd360, 13'sd0,  13'sd360,  13'sd161,  13'sd20 },
        '{ -13'sd89,  -13'sd719, -13'sd1612, 13'sd0, 13'sd1612,  13'sd719,  13'sd89 },
        '{-13'sd146, -13'sd1186, -13'sd2658, 13'sd0, 13'sd2658, 13'sd1186, 13'sd146 },
        '{ -13'sd89,  -13'sd719, -13'sd1612, 13'sd0, 13'sd1612,  13'sd719,  13'sd89 },
        '{ -13'sd20,  -13'sd161,  -13'sd360, 13'sd0,  13'sd360,  13'sd161,  13'sd20 },
        '{  -13'sd2,   -13'sd13,   -13'sd30, 13'sd0,   13'sd30,   13'sd13,   13'sd2 }
    };

    // one window tap on its way from the address sequencer to the accumulator
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] ri;
        logic [IDX_W-1:0] ci;
    } t_tap;

    // largest legal coordinate for a size register: zero acts as one, capped at maximum
    function automatic logic signed [CRD_W-1:0] size_limit(input logic [CFG_W-1:0] sz,
                                                           input int maximum);
        int s;
        s = int'(sz);
        if (s < 1) begin
            s = 1;
        end
        if (s > maximum) begin
            s = maximum;
        end
        return CRD_W'(s - 1);
    endfunction

endpackage

>>> rtl/dog7_ram.sv
// ----------------------------------------------------------------------------
// dog7_ram
// generic single-port synchronous ram, read first port, registered read
// ----------------------------------------------------------------------------
module dog7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dog7_seq.sv
// ----------------------------------------------------------------------------
// dog7_seq
// window address sequencer: walks the 7x7 window one tap a cycle, clamps
// each coordinate to the image and issues the frame store read address
// ----------------------------------------------------------------------------
module dog7_seq import dog7_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [COL_W-1:0]  i_column,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [CFG_W-1:0]  i_width,
    input  logic [CFG_W-1:0]  i_height,
    output logic [ADDR_W-1:0] o_addr,
    output t_tap              o_tap,
    output logic              o_active
);

    logic                    r_active;
    logic [IDX_W-1:0]        r_ri;
    logic [IDX_W-1:0]        r_ci;
    logic signed [CRD_W-1:0] r_ctr_c;
    logic signed [CRD_W-1:0] r_ctr_r;
    logic signed [CRD_W-1:0] r_lim_c;
    logic signed [CRD_W-1:0] r_lim_r;
    logic                    r_tap_valid;
    logic                    r_tap_first;
    logic                    r_tap_last;
    logic [IDX_W-1:0]        r_tap_ri;
    logic [IDX_W-1:0]        r_tap_ci;

    logic signed [CRD_W-1:0] crd_c;
    logic signed [CRD_W-1:0] crd_r;
    logic signed [CRD_W-1:0] cl_c;
    logic signed [CRD_W-1:0] cl_r;
    logic                    at_first;
    logic                    at_last;

    always_comb begin
        crd_c = r_ctr_c + $signed(CRD_W'(r_ci)) - $signed(CRD_W'(HALF));
        crd_r = r_ctr_r + $signed(CRD_W'(r_ri)) - $signed(CRD_W'(HALF));
        // edge replication
        cl_c  = (crd_c < 0) ? '0 : ((crd_c > r_lim_c) ? r_lim_c : crd_c);
        cl_r  = (crd_r < 0) ? '0 : ((crd_r > r_lim_r) ? r_lim_r : crd_r);
        at_first = (r_ri == '0) && (r_ci == '0);
        at_last  = (r_ri == IDX_LAST) && (r_ci == IDX_LAST);
    end

    assign o_addr = ADDR_W'(unsigned'(cl_r)) * ADDR_W'(MAX_COLUMNS)
                  + ADDR_W'(unsigned'(cl_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_ri        <= '0;
            r_ci        <= '0;
            r_tap_valid <= 1'b0;
        end else begin
            r_tap_valid <= r_active;
            if (i_go) begin
                r_active <= 1'b1;
                r_ri     <= '0;
                r_ci     <= '0;
            end else if (r_active) begin
                if (r_ci == IDX_LAST) begin
                    r_ci <= '0;
                    r_ri <= r_ri + 1'b1;
                end else begin
                    r_ci <= r_ci + 1'b1;
                end
                if (at_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_ctr_c <= $signed(CRD_W'(i_column));
            r_ctr_r <= $signed(CRD_W'(i_row));
            r_lim_c <= size_limit(i_width, MAX_COLUMNS);
            r_lim_r <= size_limit(i_height, MAX_ROWS);
        end
        r_tap_first <= at_first;
        r_tap_last  <= at_last;
        r_tap_ri    <= r_ri;
        r_tap_ci    <= r_ci;
    end

    always_comb begin
        o_tap.valid = r_tap_valid;
        o_tap.first = r_tap_first;
        o_tap.last  = r_tap_last;
        o_tap.ri    = r_tap_ri;
        o_tap.ci    = r_tap_ci;
    end

    assign o_active = r_active;

endmodule

>>> rtl/dog7_mac.sv
// ----------------------------------------------------------------------------
// dog7_mac
// weights each window pixel by both kernels, registers the products and
// accumulates them; the finished pair is held, its strobe high for one cycle
// ----------------------------------------------------------------------------
module dog7_mac import dog7_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tap                    i_tap,
    input  logic [PIX_W-1:0]        i_pixel,
    output logic                    o_pending,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_grad_x,
    output logic signed [OUT_W-1:0] o_grad_y
);

    logic signed [PIX_W:0]   px;
    logic signed [WGT_W-1:0] wx;
    logic signed [WGT_W-1:0] wy;

    logic                    r_prd_valid;
    logic                    r_prd_first;
    logic                    r_prd_last;
    logic signed [PRD_W-1:0] r_prod_x;
    logic signed [PRD_W-1:0] r_prod_y;
    logic signed [OUT_W-1:0] r_acc_x;
    logic signed [OUT_W-1:0] r_acc_y;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_grad_x;
    logic signed [OUT_W-1:0] r_grad_y;

    logic signed [OUT_W-1:0] n_acc_x;
    logic signed [OUT_W-1:0] n_acc_y;

    always_comb begin
        px = $signed({1'b0, i_pixel});
        wx = DOG_W[i_tap.ri][i_tap.ci];
        wy = DOG_W[i_tap.ci][i_tap.ri];
        n_acc_x = r_prd_first ? OUT_W'(r_prod_x) : r_acc_x + OUT_W'(r_prod_x);
        n_acc_y = r_prd_first ? OUT_W'(r_prod_y) : r_acc_y + OUT_W'(r_prod_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prd_valid <= i_tap.valid;
            r_out_valid <= r_prd_valid && r_prd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prd_first <= i_tap.first;
        r_prd_last  <= i_tap.last;
        r_prod_x    <= px * wx;
        r_prod_y    <= px * wy;
        if (r_prd_valid) begin
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
        end
        if (r_prd_valid && r_prd_last) begin
            r_grad_x <= n_acc_x;
            r_grad_y <= n_acc_y;
        end
    end

    assign o_pending = r_prd_valid;
    assign o_valid   = r_out_valid;
    assign o_grad_x  = r_grad_x;
    assign o_grad_y  = r_grad_y;

endmodule

>>> rtl/dog_gradient_7x7_clamped_unit.sv
// ----------------------------------------------------------------------------
// dog_gradient_7x7_clamped_unit
// 7x7 derivative-of-gaussian gradient over a stored 8-bit gray image
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken when start is high and busy is low. mode write
//   stores i_pixel_value at (i_column, i_row) in the same edge; writes outside
//   the store are dropped and give no result.
//   mode query reads the 7x7 window around (i_column, i_row), coordinates
//   clamped to the configured image size, and returns both gradients x 10000.
//   a query walks the window through the single frame store port, one pixel a
//   cycle; each pixel is read, multiplied and accumulated in registered steps,
//   and the result strobe o_result_valid comes once the last pixel is summed;
//   busy drops in that same cycle so the next command can be taken there.
//   the strobe is high for exactly that one cycle and the receiver cannot hold
//   it off; o_gradient_x / o_gradient_y keep the result until the next one.
//   image width and height are written on the cfg channel (always ready) while
//   the block is idle; a query samples them when it starts.
//   reset clears control state and sets both sizes to 512; the frame store is
//   not cleared, pixels must be written before a query reads them.
// ----------------------------------------------------------------------------
module dog_gradient_7x7_clamped_unit import dog7_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_mode,
    input  logic [COL_W-1:0]        i_column,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [PIX_W-1:0]        i_pixel_value,
    output logic                    o_result_valid,
    output logic signed [OUT_W-1:0] o_gradient_x,
    output logic signed [OUT_W-1:0] o_gradient_y,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    logic              accept;
    logic              go;
    logic              wr_in_range;
    logic              ram_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] seq_addr;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_rdata;
    t_tap              tap;
    logic              seq_active;
    logic              mac_pending;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(512);
            r_image_height <= CFG_W'(512);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy        = seq_active || tap.valid || mac_pending;
    assign accept      = start && !busy;
    assign go          = accept && (i_mode == MODE_QUERY);
    assign wr_in_range = (int'(i_column) < MAX_COLUMNS) && (int'(i_row) < MAX_ROWS);
    assign ram_we      = accept && (i_mode == MODE_WRITE) && wr_in_range;
    assign wr_addr     = ADDR_W'(i_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(i_column);
    // the port is free for a write beat only while no query is walking
    assign ram_addr    = ram_we ? wr_addr : seq_addr;

    dog7_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLUMNS * MAX_ROWS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel_value),
        .o_rdata (ram_rdata)
    );

    dog7_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_column (i_column),
        .i_row    (i_row),
        .i_width  (r_image_width),
        .i_height (r_image_height),
        .o_addr   (seq_addr),
        .o_tap    (tap),
        .o_active (seq_active)
    );

    dog7_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tap     (tap),
        .i_pixel   (ram_rdata),
        .o_pending (mac_pending),
        .o_valid   (o_result_valid),
        .o_grad_x  (o_gradient_x),
        .o_grad_y  (o_gradient_y)
    );

    // a query keeps the block busy from the next cycle on
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> busy)
        else $error("query accepted but block not busy");

    // a result only ends a query that held the block busy
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a query in flight");

    // one strobe per query, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule
